// ===== rtl/hes_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heat equation stencil package
// Shared constants, codes, control types and fixed-point helpers.
// ----------------------------------------------------------------------------
package hes_pkg;

  localparam int GRID_POINTS_DEF = 64;
  localparam int DIV_STEPS       = 25;

  localparam logic [24:0] ONE_Q24 = 25'd16777216;

  // Register reset values.
  localparam logic        MODE_RST  = 1'b0;
  localparam logic [23:0] RATIO_RST = 24'd6710886;
  localparam logic [24:0] DX_RST    = 25'd335544;
  localparam logic [24:0] DT_RST    = 25'd2684;
  localparam logic [26:0] LIMIT_RST = 27'd20971520;
  localparam logic [5:0]  LAST_RST  = 6'd50;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_RATIO = 3'd1,
    REG_DX    = 3'd2,
    REG_DT    = 3'd3,
    REG_LIMIT = 3'd4,
    REG_LAST  = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_ADVANCE = 2'd0,
    KIND_READ    = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PE_COEF   = 3'd0,
    PE_MUL_R  = 3'd1,
    PE_MUL_C  = 3'd2,
    PE_MUL_L  = 3'd3,
    PE_SUM    = 3'd4,
    PE_ROUND  = 3'd5,
    PE_MUL_Q  = 3'd6,
    PE_FINISH = 3'd7
  } pe_op_e;

  typedef struct packed {
    logic   en;
    pe_op_e op;
    logic   var_mode;
  } pe_ctl_t;

  // Drop 24 fraction bits, rounding half away from zero.
  function automatic logic signed [35:0] round_q24(input logic signed [59:0] v);
    logic signed [59:0] a;
    if (v >= 60'sd0) begin
      a = (v + 60'sd8388608) >>> 24;
    end else begin
      a = -((-v + 60'sd8388608) >>> 24);
    end
    return a[35:0];
  endfunction

  // Saturate to the unit interval.
  function automatic logic [24:0] clamp_unit(input logic signed [36:0] v);
    logic [24:0] r;
    if (v < 37'sd0) begin
      r = '0;
    end else if (v > 37'sd16777216) begin
      r = ONE_Q24;
    end else begin
      r = v[24:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hes_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heat equation stencil channels
// Item, result and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hes_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [5:0] index;
  modport source (output valid, kind, index, input ready);
  modport sink (input valid, kind, index, output ready);
endinterface

interface hes_result_if;
  logic        valid;
  logic        ready;
  logic [24:0] value;
  logic [31:0] time_now;
  modport source (output valid, value, time_now, input ready);
  modport sink (input valid, value, time_now, output ready);
endinterface

interface hes_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/heat_equation_stencil_step_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Advance: the boundary divider starts when the word is taken and runs beside the interior
//   sweep; ST_BND0 waits for it if the sweep ends first.
// Read, clear and an unused kind each return one result word through ST_REPLY.
// One word is in work at a time; the result register frees the output side.
// Reset: registers take their defaults and a clearing pass writes zero to all
//   GRID_POINTS memory entries, one per cycle, before the first word is taken.
// ----------------------------------------------------------------------------
// Heat equation stencil step core
// Explicit FTCS sweep over a grid held in a synchronous memory.
// ----------------------------------------------------------------------------
module heat_equation_stencil_step_core #(
  parameter int GRID_POINTS = hes_pkg::GRID_POINTS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  hes_item_if.sink     item_i,
  hes_result_if.source result_o,
  hes_cfg_if.sink      cfg_i
);
  import hes_pkg::*;

  localparam int AW = $clog2(GRID_POINTS);
  localparam int CW = (AW + 1 > 7) ? AW + 1 : 7;

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_RD_WAIT, ST_PRE, ST_PT, ST_BND0, ST_BNDL, ST_REPLY
  } state_e;

  state_e      state_q;
  pe_op_e      pstep_q;
  logic        clr_reply_q;
  logic [AW-1:0] cnt_q, i_q, last_q;
  logic [31:0] sim_time_q, x_q;
  logic [24:0] g0_q, c_q, l_q, r_q, res_value_q;

  logic        mode_q;
  logic [23:0] ratio_q;
  logic [24:0] dx_q, dt_q;
  logic [26:0] limit_q;
  logic [5:0]  last_idx_q;

  logic        out_valid_q;
  logic [24:0] out_value_q;
  logic [31:0] out_time_q;

  logic [24:0] mem [GRID_POINTS];
  logic [24:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [24:0]   mem_wd;

  logic [32:0] t_sum;
  logic [31:0] t_new;
  logic [CW-1:0] idx_ext, last_ext, last_c;
  logic        item_acc, slot_free, div_start, div_done;
  logic [24:0] div_quo, nv;
  pe_ctl_t     pe_ctl;

  assign item_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign item_acc     = item_i.valid && item_i.ready;
  assign slot_free    = !out_valid_q || result_o.ready;

  assign result_o.valid    = out_valid_q;
  assign result_o.value    = out_value_q;
  assign result_o.time_now = out_time_q;

  assign t_sum = {1'b0, sim_time_q} + 33'(dt_q);
  assign t_new = t_sum[32] ? '1 : t_sum[31:0];

  assign idx_ext  = CW'(item_i.index);
  assign last_ext = CW'(last_idx_q);
  always_comb begin
    if (last_ext < CW'(2)) begin
      last_c = CW'(2);
    end else if (last_ext > CW'(GRID_POINTS - 1)) begin
      last_c = CW'(GRID_POINTS - 1);
    end else begin
      last_c = last_ext;
    end
  end

  assign div_start = item_acc && (kind_e'(item_i.kind) == KIND_ADVANCE);

  hes_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .t_i     (t_new),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign pe_ctl = '{en: (state_q == ST_PT), op: pstep_q, var_mode: mode_q};

  hes_pe u_pe (
    .clk_i   (clk_i),
    .ctl_i   (pe_ctl),
    .x_i     (x_q),
    .t_i     (sim_time_q),
    .dx_i    (dx_q),
    .ratio_i (ratio_q),
    .limit_i (limit_q),
    .rd_i    (rdata_q),
    .c_i     (c_q),
    .l_i     (l_q),
    .nv_o    (nv)
  );

  // Memory address and write selection.
  always_comb begin
    mem_ra = '0;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    case (state_q)
      ST_IDLE: begin
        if (kind_e'(item_i.kind) == KIND_READ) begin
          mem_ra = AW'(idx_ext);
        end else begin
          mem_ra = AW'(1);
        end
      end
      ST_PT: begin
        mem_ra = i_q + AW'(1);
        if (pstep_q == PE_FINISH) begin
          mem_we = 1'b1;
          mem_wa = i_q;
          mem_wd = nv;
        end
      end
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = cnt_q;
      end
      ST_BND0: begin
        mem_we = div_done;
        mem_wd = div_quo;
      end
      ST_BNDL: begin
        mem_we = 1'b1;
        mem_wa = last_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_RST;
      ratio_q    <= RATIO_RST;
      dx_q       <= DX_RST;
      dt_q       <= DT_RST;
      limit_q    <= LIMIT_RST;
      last_idx_q <= LAST_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_MODE:  mode_q     <= cfg_i.data[0];
        REG_RATIO: ratio_q    <= cfg_i.data[23:0];
        REG_DX:    dx_q       <= cfg_i.data[24:0];
        REG_DT:    dt_q       <= cfg_i.data[24:0];
        REG_LIMIT: limit_q    <= cfg_i.data[26:0];
        REG_LAST:  last_idx_q <= cfg_i.data[5:0];
        default: ;
      endcase
    end
  end

  // Sequencer, grid state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      pstep_q     <= PE_COEF;
      clr_reply_q <= 1'b0;
      cnt_q       <= '0;
      i_q         <= '0;
      last_q      <= '0;
      sim_time_q  <= '0;
      g0_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // In ST_REPLY a ready output always refills the result register below.
      if (result_o.ready && state_q != ST_REPLY) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLR: begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == AW'(GRID_POINTS - 1)) begin
            res_value_q <= '0;
            state_q     <= clr_reply_q ? ST_REPLY : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_acc) begin
            case (kind_e'(item_i.kind))
              KIND_ADVANCE: begin
                sim_time_q <= t_new;
                last_q     <= last_c[AW-1:0];
                state_q    <= ST_PRE;
              end
              KIND_READ: begin
                if (idx_ext < CW'(GRID_POINTS)) begin
                  state_q <= ST_RD_WAIT;
                end else begin
                  res_value_q <= '0;
                  state_q     <= ST_REPLY;
                end
              end
              KIND_CLEAR: begin
                sim_time_q  <= '0;
                g0_q        <= '0;
                cnt_q       <= '0;
                clr_reply_q <= 1'b1;
                state_q     <= ST_CLR;
              end
              default: begin
                res_value_q <= g0_q;
                state_q     <= ST_REPLY;
              end
            endcase
          end
        end
        ST_RD_WAIT: begin
          res_value_q <= rdata_q;
          state_q     <= ST_REPLY;
        end
        ST_PRE: begin
          c_q     <= rdata_q;
          l_q     <= g0_q;
          i_q     <= AW'(1);
          x_q     <= 32'(dx_q);
          pstep_q <= PE_COEF;
          state_q <= ST_PT;
        end
        ST_PT: begin
          case (pstep_q)
            PE_COEF:  pstep_q <= PE_MUL_R;
            PE_MUL_R: begin
              r_q     <= rdata_q;
              pstep_q <= PE_MUL_C;
            end
            PE_MUL_C: pstep_q <= PE_MUL_L;
            PE_MUL_L: pstep_q <= PE_SUM;
            PE_SUM:   pstep_q <= PE_ROUND;
            PE_ROUND: pstep_q <= PE_MUL_Q;
            PE_MUL_Q: pstep_q <= PE_FINISH;
            default: begin
              l_q     <= c_q;
              c_q     <= r_q;
              x_q     <= x_q + 32'(dx_q);
              pstep_q <= PE_COEF;
              if (i_q == last_q - AW'(1)) begin
                state_q <= ST_BND0;
              end else begin
                i_q <= i_q + AW'(1);
              end
            end
          endcase
        end
        ST_BND0: begin
          if (div_done) begin
            g0_q        <= div_quo;
            res_value_q <= div_quo;
            state_q     <= ST_BNDL;
          end
        end
        ST_BNDL: state_q <= ST_REPLY;
        ST_REPLY: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_value_q <= res_value_q;
            out_time_q  <= sim_time_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_value_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.value <= ONE_Q24))
    else $error("result word value above one");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_acc |=> !item_i.ready)
    else $error("item taken while the previous word is in work");

  a_write_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mem_wd <= ONE_Q24))
    else $error("grid write outside the unit interval");

  a_boundary_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BNDL) |-> ($past(state_q) == ST_BND0) && $past(div_done))
    else $error("right boundary written before the left boundary");
`endif

endmodule
`default_nettype wire

// ===== rtl/hes_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Boundary divider
// Restoring divider for round(t * 2^24 / (t + 2^24)), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module hes_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] t_i,
  output logic        done_o,
  output logic [24:0] quo_o
);
  import hes_pkg::*;

  logic [32:0] den_d, den_q;
  logic [32:0] rem_q;
  logic [24:0] lo_q, quo_q;
  logic [4:0]  cnt_q;
  logic        run_q, done_q;
  logic [56:0] num;
  logic [33:0] trial;
  logic        qbit;

  assign den_d = {1'b0, t_i} + 33'(ONE_Q24);
  assign num   = {1'b0, t_i, 24'd0} + 57'(den_d[32:1]);
  assign trial = {rem_q, lo_q[24]};
  assign qbit  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'(DIV_STEPS - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // The quotient is below 2^25, so the top bits of the numerator start below den.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_d;
      rem_q <= {1'b0, num[56:25]};
      lo_q  <= num[24:0];
    end else if (run_q) begin
      rem_q <= qbit ? 33'(trial - {1'b0, den_q}) : trial[32:0];
      lo_q  <= {lo_q[23:0], 1'b0};
      quo_q <= {quo_q[23:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// ===== rtl/hes_pe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stencil point engine
// Face coefficients and a shared multiplier stepping through one point update.
// ----------------------------------------------------------------------------
module hes_pe (
  input  logic             clk_i,
  input  hes_pkg::pe_ctl_t ctl_i,
  input  logic [31:0]      x_i,
  input  logic [31:0]      t_i,
  input  logic [24:0]      dx_i,
  input  logic [23:0]      ratio_i,
  input  logic [26:0]      limit_i,
  input  logic [24:0]      rd_i,
  input  logic [24:0]      c_i,
  input  logic [24:0]      l_i,
  output logic [24:0]      nv_o
);
  import hes_pkg::*;

  logic [26:0]        ap_q, am_q;
  logic [33:0]        ap_raw, am_raw, xt;
  logic signed [59:0] prod_q, acc_q;
  logic signed [33:0] d_q;
  logic signed [29:0] kp, km, kc;
  logic signed [33:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [35:0] upd;

  assign xt     = 34'(x_i) + 34'(t_i);
  assign ap_raw = xt + 34'(dx_i[24:1]);
  assign am_raw = xt - 34'(dx_i - {1'b0, dx_i[24:1]});

  always_comb begin
    if (ctl_i.var_mode) begin
      kp = 30'(ap_q);
      km = 30'(am_q);
      kc = -(30'(ap_q) + 30'(am_q));
    end else begin
      kp = 30'(ratio_i);
      km = 30'(ratio_i);
      kc = 30'(ONE_Q24) - {5'd0, ratio_i, 1'b0};
    end
  end

  always_comb begin
    case (ctl_i.op)
      PE_MUL_R: begin
        mul_a = 34'(kp);
        mul_b = {1'b0, rd_i};
      end
      PE_MUL_C: begin
        mul_a = 34'(kc);
        mul_b = {1'b0, c_i};
      end
      PE_MUL_L: begin
        mul_a = 34'(km);
        mul_b = {1'b0, l_i};
      end
      PE_MUL_Q: begin
        mul_a = d_q;
        mul_b = {2'b00, ratio_i};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      case (ctl_i.op)
        PE_COEF: begin
          ap_q <= (ap_raw > 34'(limit_i)) ? limit_i : ap_raw[26:0];
          am_q <= (am_raw > 34'(limit_i)) ? limit_i : am_raw[26:0];
        end
        PE_MUL_R: prod_q <= mul_a * mul_b;
        PE_MUL_C: begin
          acc_q  <= prod_q;
          prod_q <= mul_a * mul_b;
        end
        PE_MUL_L: begin
          acc_q  <= acc_q + prod_q;
          prod_q <= mul_a * mul_b;
        end
        PE_SUM:   acc_q <= acc_q + prod_q;
        PE_ROUND: d_q <= 34'(round_q24(acc_q));
        PE_MUL_Q: prod_q <= mul_a * mul_b;
        default: ;
      endcase
    end
  end

  assign upd  = round_q24(prod_q);
  assign nv_o = ctl_i.var_mode ? clamp_unit(37'(upd) + 37'({1'b0, c_i}))
                               : clamp_unit(37'(d_q));

endmodule
`default_nettype wire
